// ===== hw/rtl/cfpg_pkg.sv =====
// cfpg_pkg: shared types, register codes and defaults for the color fade pixel generator.
// No dependencies; imported by every module of the block.
package cfpg_pkg;

  localparam int DEF_COORD_BITS    = 12;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int DIM_BITS          = 13;
  localparam int COLOR_BITS        = 32;
  localparam int CHAN_BITS         = 8;
  localparam int NUM_CHAN          = 4;
  localparam int CFG_IDX_BITS      = 3;

  localparam logic [DIM_BITS-1:0]   RST_FRAME_WIDTH  = 13'd640;
  localparam logic [DIM_BITS-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [COLOR_BITS-1:0] RST_START_COLOR  = 32'h0000_0000;
  localparam logic [COLOR_BITS-1:0] RST_END_COLOR    = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_START_COLOR  = 3'd2,
    CFG_END_COLOR    = 3'd3,
    CFG_FADE_MODE    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_HORIZ  = 2'd0,
    MODE_VERT   = 2'd1,
    MODE_RADIAL = 2'd2,
    MODE_NONE   = 2'd3
  } fade_mode_t;

  // travels with each word down the pipeline
  typedef struct packed {
    logic valid;
    logic sat;
  } ctl_t;

endpackage

// ===== hw/rtl/cfpg_front.sv =====
// cfpg_front: three stages that turn a coordinate into divider operands (offsets, squares,
// saturation). Depends on cfpg_pkg.
module cfpg_front import cfpg_pkg::*; #(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [COORD_BITS-1:0]                 pixel_x,
  input  logic [COORD_BITS-1:0]                 pixel_y,
  input  logic [DIM_BITS-1:0]                   frame_width,
  input  logic [DIM_BITS-1:0]                   frame_height,
  input  fade_mode_t                            fade_mode,
  output ctl_t                                  out_ctl,
  output logic [2*((COORD_BITS+1 > DIM_BITS) ? COORD_BITS+1 : DIM_BITS)-1:0] num_x,
  output logic [2*((COORD_BITS+1 > DIM_BITS) ? COORD_BITS+1 : DIM_BITS)-1:0] num_y,
  output logic [2*((COORD_BITS+1 > DIM_BITS) ? COORD_BITS+1 : DIM_BITS)-1:0] den_x,
  output logic [2*((COORD_BITS+1 > DIM_BITS) ? COORD_BITS+1 : DIM_BITS)-1:0] den_y
);

  localparam int DW = (COORD_BITS+1 > DIM_BITS) ? COORD_BITS+1 : DIM_BITS;
  localparam int RW = 2*DW;
  localparam int HB = DIM_BITS-1;

  // frame-derived divisors, follow the registers every cycle
  logic [DIM_BITS-1:0] wm1, hm1;
  logic [HB-1:0]       half_w, half_h;
  logic [2*HB-1:0]     sq_w, sq_h;
  logic [RW-1:0]       rad_w, rad_h;
  logic [RW-1:0]       den_x_r, den_y_r;

  assign wm1    = frame_width - 1'b1;
  assign hm1    = frame_height - 1'b1;
  assign half_w = frame_width[DIM_BITS-1:1];
  assign half_h = frame_height[DIM_BITS-1:1];
  assign sq_w   = half_w * half_w;
  assign sq_h   = half_h * half_h;
  assign rad_w  = RW'({sq_w, 2'b00});
  assign rad_h  = RW'({sq_h, 2'b00});

  always_ff @(posedge clk) begin
    case (fade_mode)
      MODE_HORIZ:  den_x_r <= {{(RW-DIM_BITS){1'b0}}, wm1};
      MODE_VERT:   den_x_r <= {{(RW-DIM_BITS){1'b0}}, hm1};
      MODE_RADIAL: den_x_r <= rad_w;
      default:     den_x_r <= {{(RW-1){1'b0}}, 1'b1};
    endcase
    den_y_r <= (fade_mode == MODE_RADIAL) ? rad_h : {{(RW-1){1'b0}}, 1'b1};
  end

  assign den_x = den_x_r;
  assign den_y = den_y_r;

  // stage 1: distance of twice the coordinate from the frame size
  logic [DW:0]           twice_x, twice_y, size_w, size_h, diff_x, diff_y;
  logic                  v1_r;
  logic [COORD_BITS-1:0] x1_r, y1_r;
  logic [DW-1:0]         dx1_r, dy1_r;

  assign twice_x = {{(DW-COORD_BITS){1'b0}}, pixel_x, 1'b0};
  assign twice_y = {{(DW-COORD_BITS){1'b0}}, pixel_y, 1'b0};
  assign size_w  = {{(DW+1-DIM_BITS){1'b0}}, frame_width};
  assign size_h  = {{(DW+1-DIM_BITS){1'b0}}, frame_height};
  assign diff_x  = (twice_x >= size_w) ? (twice_x - size_w) : (size_w - twice_x);
  assign diff_y  = (twice_y >= size_h) ? (twice_y - size_h) : (size_h - twice_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= pixel_x;
      y1_r  <= pixel_y;
      dx1_r <= diff_x[DW-1:0];
      dy1_r <= diff_y[DW-1:0];
    end
  end

  // stage 2: squares
  logic                  v2_r;
  logic [COORD_BITS-1:0] x2_r, y2_r;
  logic [RW-1:0]         ddx2_r, ddy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      ddx2_r <= dx1_r * dx1_r;
      ddy2_r <= dy1_r * dy1_r;
    end
  end

  // stage 3: saturation and numerators
  logic [DW-1:0] x_ext, y_ext, wm1_ext, hm1_ext;
  logic [RW-1:0] nx, ny;
  logic          sat, sat_x, sat_y;
  ctl_t          ctl_r;
  logic [RW-1:0] num_x_r, num_y_r;

  assign x_ext   = {{(DW-COORD_BITS){1'b0}}, x2_r};
  assign y_ext   = {{(DW-COORD_BITS){1'b0}}, y2_r};
  assign wm1_ext = {{(DW-DIM_BITS){1'b0}}, wm1};
  assign hm1_ext = {{(DW-DIM_BITS){1'b0}}, hm1};

  always_comb begin
    sat_x = 1'b0;
    sat_y = 1'b0;
    sat   = 1'b0;
    nx    = '0;
    ny    = '0;
    case (fade_mode)
      MODE_HORIZ: begin
        sat = (frame_width < 13'd2) || (x_ext >= wm1_ext);
        nx  = sat ? '0 : {{(RW-DW){1'b0}}, x_ext};
      end
      MODE_VERT: begin
        sat = (frame_height < 13'd2) || (y_ext >= hm1_ext);
        nx  = sat ? '0 : {{(RW-DW){1'b0}}, y_ext};
      end
      MODE_RADIAL: begin
        sat_x = (half_w == '0) || (ddx2_r >= den_x_r);
        sat_y = (half_h == '0) || (ddy2_r >= den_y_r);
        sat   = sat_x || sat_y;
        nx    = sat_x ? '0 : ddx2_r;
        ny    = sat_y ? '0 : ddy2_r;
      end
      default: begin
        sat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.sat <= sat;
      num_x_r   <= nx;
      num_y_r   <= ny;
    end
  end

  assign out_ctl = ctl_r;
  assign num_x   = num_x_r;
  assign num_y   = num_y_r;

endmodule

// ===== hw/rtl/cfpg_div.sv =====
// cfpg_div: two restoring divider lanes, one quotient bit per pipeline stage (2F stages).
// Lane x also forms the round-to-nearest bit after F steps. Depends on cfpg_pkg.
module cfpg_div import cfpg_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int REM_BITS      = 2*DIM_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  ctl_t                       in_ctl,
  input  logic [REM_BITS-1:0]        num_x,
  input  logic [REM_BITS-1:0]        num_y,
  input  logic [REM_BITS-1:0]        den_x,
  input  logic [REM_BITS-1:0]        den_y,
  output ctl_t                       out_ctl,
  output logic [2*FRACTION_BITS-1:0] q_x,
  output logic [2*FRACTION_BITS-1:0] q_y,
  output logic                       rnd_x
);

  localparam int NS = 2*FRACTION_BITS;
  localparam int QW = 2*FRACTION_BITS;

  ctl_t                ctl_r [NS];
  logic [REM_BITS-1:0] rx_r  [NS];
  logic [REM_BITS-1:0] ry_r  [NS];
  logic [QW-1:0]       qx_r  [NS];
  logic [QW-1:0]       qy_r  [NS];
  logic                rnd_r [NS];

  logic [REM_BITS:0] den_x_ext, den_y_ext, half_x_ext;
  assign den_x_ext  = {1'b0, den_x};
  assign den_y_ext  = {1'b0, den_y};
  assign half_x_ext = {2'b00, den_x[REM_BITS-1:1]};

  for (genvar k = 0; k < NS; k++) begin : g_step
    ctl_t                c_in;
    logic [REM_BITS-1:0] rx_in, ry_in;
    logic [QW-1:0]       qx_in, qy_in;
    logic [REM_BITS:0]   tx, ty, sx, sy;
    logic                gx, gy;

    if (k == 0) begin : g_first
      assign c_in  = in_ctl;
      assign rx_in = num_x;
      assign ry_in = num_y;
      assign qx_in = '0;
      assign qy_in = '0;
    end else begin : g_next
      assign c_in  = ctl_r[k-1];
      assign rx_in = rx_r[k-1];
      assign ry_in = ry_r[k-1];
      assign qx_in = qx_r[k-1];
      assign qy_in = qy_r[k-1];
    end

    assign tx = {rx_in, 1'b0};
    assign ty = {ry_in, 1'b0};
    assign gx = tx >= den_x_ext;
    assign gy = ty >= den_y_ext;
    assign sx = gx ? (tx - den_x_ext) : tx;
    assign sy = gy ? (ty - den_y_ext) : ty;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k].valid <= 1'b0;
      end else if (en) begin
        ctl_r[k].valid <= c_in.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[k].sat <= c_in.sat;
        rx_r[k]      <= sx[REM_BITS-1:0];
        ry_r[k]      <= sy[REM_BITS-1:0];
        qx_r[k]      <= {qx_in[QW-2:0], gx};
        qy_r[k]      <= {qy_in[QW-2:0], gy};
      end
    end

    // remainder after F steps decides rounding of the linear factor
    if (k < FRACTION_BITS) begin : g_pre
      always_ff @(posedge clk) begin
        if (en) begin
          rnd_r[k] <= 1'b0;
        end
      end
    end else if (k == FRACTION_BITS) begin : g_rnd
      always_ff @(posedge clk) begin
        if (en) begin
          rnd_r[k] <= ({1'b0, rx_in} + half_x_ext) >= den_x_ext;
        end
      end
    end else begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rnd_r[k] <= rnd_r[k-1];
        end
      end
    end
  end

  assign out_ctl = ctl_r[NS-1];
  assign q_x     = qx_r[NS-1];
  assign q_y     = qy_r[NS-1];
  assign rnd_x   = rnd_r[NS-1];

endmodule

// ===== hw/rtl/cfpg_sqrt.sv =====
// cfpg_sqrt: sums the radial terms, pipelined integer square root (one result bit per stage),
// rounding and factor select. Depends on cfpg_pkg.
module cfpg_sqrt import cfpg_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  ctl_t                       in_ctl,
  input  logic [2*FRACTION_BITS-1:0] q_x,
  input  logic [2*FRACTION_BITS-1:0] q_y,
  input  logic                       rnd_x,
  input  fade_mode_t                 fade_mode,
  output logic                       out_valid,
  output logic [FRACTION_BITS:0]     factor
);

  localparam int F  = FRACTION_BITS;
  localparam int SW = 2*FRACTION_BITS+1;
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  // sum stage
  logic [SW-1:0] sum;
  ctl_t          ca_r;
  logic [F:0]    flin_a_r;
  logic [SW-1:0] va_r;

  assign sum = {1'b0, q_x} + {1'b0, q_y};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r.valid <= 1'b0;
    end else if (en) begin
      ca_r.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r.sat <= in_ctl.sat || sum[SW-1];
      flin_a_r <= {1'b0, q_x[2*F-1:F]} + {{F{1'b0}}, rnd_x};
      va_r     <= sum;
    end
  end

  // root stages
  ctl_t          ctl_r  [F];
  logic [F:0]    flin_r [F];
  logic [SW-1:0] v_r    [F];
  logic [SW-1:0] r_r    [F];

  for (genvar k = 0; k < F; k++) begin : g_root
    localparam logic [SW-1:0] BIT = SW'(1) << (2*(F-1-k));
    ctl_t          c_in;
    logic [F:0]    fl_in;
    logic [SW-1:0] v_in, r_in, trial;
    logic          take;

    if (k == 0) begin : g_first
      assign c_in  = ca_r;
      assign fl_in = flin_a_r;
      assign v_in  = va_r;
      assign r_in  = '0;
    end else begin : g_next
      assign c_in  = ctl_r[k-1];
      assign fl_in = flin_r[k-1];
      assign v_in  = v_r[k-1];
      assign r_in  = r_r[k-1];
    end

    assign trial = r_in + BIT;
    assign take  = v_in >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k].valid <= 1'b0;
      end else if (en) begin
        ctl_r[k].valid <= c_in.valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctl_r[k].sat <= c_in.sat;
        flin_r[k]    <= fl_in;
        v_r[k]       <= take ? (v_in - trial) : v_in;
        r_r[k]       <= take ? ((r_in >> 1) + BIT) : (r_in >> 1);
      end
    end
  end

  // round to nearest and pick the factor for the mode
  logic [F:0] f_rad, f_sel;
  logic       vo_r;
  logic [F:0] factor_r;

  assign f_rad = r_r[F-1][F:0] + {{F{1'b0}}, (v_r[F-1] > r_r[F-1])};

  always_comb begin
    case (fade_mode)
      MODE_HORIZ, MODE_VERT: f_sel = ctl_r[F-1].sat ? ONE : flin_r[F-1];
      MODE_RADIAL:           f_sel = ctl_r[F-1].sat ? ONE : f_rad;
      default:               f_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vo_r <= 1'b0;
    end else if (en) begin
      vo_r <= ctl_r[F-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      factor_r <= f_sel;
    end
  end

  assign out_valid = vo_r;
  assign factor    = factor_r;

endmodule

// ===== hw/rtl/cfpg_blend.sv =====
// cfpg_blend: per-channel mix end + (start - end) * factor, rounded; multiply stage then
// add stage, whose register is the output register. Depends on cfpg_pkg.
module cfpg_blend import cfpg_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [FRACTION_BITS:0] factor,
  input  logic [COLOR_BITS-1:0]  start_color,
  input  logic [COLOR_BITS-1:0]  end_color,
  output logic                   out_valid,
  output logic [CHAN_BITS-1:0]   chan [NUM_CHAN]
);

  localparam int F  = FRACTION_BITS;
  localparam int AW = F + CHAN_BITS + 3;
  localparam logic signed [AW-1:0] HALF = AW'(1) << (F-1);

  logic                        vm_r, vo_r;
  logic signed [AW-1:0]        prod_r [NUM_CHAN];
  logic        [CHAN_BITS-1:0] chan_r [NUM_CHAN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vm_r <= in_valid;
      vo_r <= vm_r;
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    logic        [CHAN_BITS-1:0] s_c, e_c;
    logic signed [CHAN_BITS:0]   diff;
    logic signed [AW-1:0]        base, acc;

    // red sits in the top byte
    assign s_c  = start_color[COLOR_BITS-1-CHAN_BITS*c -: CHAN_BITS];
    assign e_c  = end_color[COLOR_BITS-1-CHAN_BITS*c -: CHAN_BITS];
    assign diff = $signed({1'b0, s_c}) - $signed({1'b0, e_c});
    assign base = $signed({{(AW-CHAN_BITS-F){1'b0}}, e_c, {F{1'b0}}});
    assign acc  = base + prod_r[c] + HALF;

    always_ff @(posedge clk) begin
      if (en) begin
        prod_r[c] <= diff * $signed({1'b0, factor});
        chan_r[c] <= acc[F+CHAN_BITS-1:F];
      end
    end

    assign chan[c] = chan_r[c];
  end

  assign out_valid = vo_r;

endmodule

// ===== hw/rtl/color_fade_pixel_generator.sv =====
// color_fade_pixel_generator: top level; configuration registers, input register and the
// pipeline front -> div -> sqrt -> blend. Depends on cfpg_pkg and the cfpg_* modules.
//
//  channel | direction | handshake           | words
//  in_     | input     | in_valid / in_stall | in_pixel_x, in_pixel_y
//  out_    | output    | out_valid/out_stall | out_red_out .. out_alpha_out
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One pixel per clock while the output is not stalled; the pipeline depth is set by
// the one-bit-per-stage divider (2F stages) and square root (F stages).
// rst_n is synchronous; it clears valid bits and loads the register defaults.
// An output stall while out_valid is high freezes the whole pipeline and raises in_stall in the same cycle.
// cfg_ready is always high.
module color_fade_pixel_generator import cfpg_pkg::*; #(
  parameter int COORD_BITS    = DEF_COORD_BITS,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [COORD_BITS-1:0]   in_pixel_x,
  input  logic [COORD_BITS-1:0]   in_pixel_y,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [CHAN_BITS-1:0]    out_red_out,
  output logic [CHAN_BITS-1:0]    out_green_out,
  output logic [CHAN_BITS-1:0]    out_blue_out,
  output logic [CHAN_BITS-1:0]    out_alpha_out,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COLOR_BITS-1:0]   cfg_data
);

  localparam int DW = (COORD_BITS+1 > DIM_BITS) ? COORD_BITS+1 : DIM_BITS;
  localparam int RW = 2*DW;

  // configuration registers
  logic [DIM_BITS-1:0]   frame_width_r, frame_height_r;
  logic [COLOR_BITS-1:0] start_color_r, end_color_r;
  fade_mode_t            fade_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      start_color_r  <= RST_START_COLOR;
      end_color_r    <= RST_END_COLOR;
      fade_mode_r    <= MODE_HORIZ;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[DIM_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[DIM_BITS-1:0];
        CFG_START_COLOR:  start_color_r  <= cfg_data;
        CFG_END_COLOR:    end_color_r    <= cfg_data;
        CFG_FADE_MODE:    fade_mode_r    <= fade_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // pipeline advance
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic                  v0_r;
  logic [COORD_BITS-1:0] x0_r, y0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0_r <= in_pixel_x;
      y0_r <= in_pixel_y;
    end
  end

  ctl_t                       front_ctl, div_ctl;
  logic [RW-1:0]              num_x, num_y, den_x, den_y;
  logic [2*FRACTION_BITS-1:0] q_x, q_y;
  logic                       rnd_x;
  logic                       fac_valid;
  logic [FRACTION_BITS:0]     factor;
  logic [CHAN_BITS-1:0]       chan [NUM_CHAN];

  cfpg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (v0_r),
    .pixel_x      (x0_r),
    .pixel_y      (y0_r),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .fade_mode    (fade_mode_r),
    .out_ctl      (front_ctl),
    .num_x        (num_x),
    .num_y        (num_y),
    .den_x        (den_x),
    .den_y        (den_y)
  );

  cfpg_div #(
    .FRACTION_BITS(FRACTION_BITS),
    .REM_BITS     (RW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_ctl  (front_ctl),
    .num_x   (num_x),
    .num_y   (num_y),
    .den_x   (den_x),
    .den_y   (den_y),
    .out_ctl (div_ctl),
    .q_x     (q_x),
    .q_y     (q_y),
    .rnd_x   (rnd_x)
  );

  cfpg_sqrt #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_ctl    (div_ctl),
    .q_x       (q_x),
    .q_y       (q_y),
    .rnd_x     (rnd_x),
    .fade_mode (fade_mode_r),
    .out_valid (fac_valid),
    .factor    (factor)
  );

  cfpg_blend #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_blend (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (fac_valid),
    .factor      (factor),
    .start_color (start_color_r),
    .end_color   (end_color_r),
    .out_valid   (out_valid),
    .chan        (chan)
  );

  assign out_red_out   = chan[0];
  assign out_green_out = chan[1];
  assign out_blue_out  = chan[2];
  assign out_alpha_out = chan[3];

`ifndef SYNTHESIS
  a_reset_clears_out : assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set after reset");
  a_stall_holds_word : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_out) && $stable(out_alpha_out))
    else $error("stalled output word changed");
  a_factor_range : assert property (@(posedge clk) disable iff (!rst_n)
    fac_valid |-> factor <= {1'b1, {FRACTION_BITS{1'b0}}})
    else $error("fade factor above one");
  a_freeze_front : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v0_r) && $stable(front_ctl))
    else $error("pipeline moved during stall");
`endif

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for color_fade_pixel_generator (horizontal, vertical,
// radial and unused fade modes). Depends on cfpg_pkg and the RTL; predicts every word in fixed point.
module tb_top;
  import cfpg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = DEF_COORD_BITS;
  localparam int FB = DEF_FRACTION_BITS;
  localparam longint unsigned ONE = 64'd1 << FB;
  localparam longint unsigned SQ_ONE = 64'd1 << (2 * FB);
  localparam int LATENCY = 3 * FB + 9;
  localparam int LIMIT = 400000;

  typedef struct {
    logic [CHAN_BITS-1:0] red;
    logic [CHAN_BITS-1:0] green;
    logic [CHAN_BITS-1:0] blue;
    logic [CHAN_BITS-1:0] alpha;
  } rgba_t;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CB-1:0] in_pixel_x = '0;
  logic [CB-1:0] in_pixel_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CHAN_BITS-1:0] out_red_out, out_green_out, out_blue_out, out_alpha_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [COLOR_BITS-1:0] cfg_data = '0;

  color_fade_pixel_generator uut (.*);

  // local copy of the register file
  logic [DIM_BITS-1:0] m_width = RST_FRAME_WIDTH;
  logic [DIM_BITS-1:0] m_height = RST_FRAME_HEIGHT;
  logic [COLOR_BITS-1:0] m_start = RST_START_COLOR;
  logic [COLOR_BITS-1:0] m_end = RST_END_COLOR;
  fade_mode_t m_mode = MODE_HORIZ;

  coord_t pixel_q[$];
  rgba_t color_q[$];
  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int phases = 0;
  int in_gap = 0;
  int stall_left = 0;
  bit no_idle = 1'b0;

  initial forever #2 clk = ~clk;

  function automatic longint unsigned lin_factor(longint unsigned pos, longint unsigned size);
    longint unsigned d;
    if (size < 2) return ONE;
    d = size - 1;
    if (pos >= d) return ONE;
    return ((pos << FB) + (d >> 1)) / d;
  endfunction

  function automatic longint unsigned rad_term(longint unsigned pos, longint unsigned size);
    longint unsigned half, d, den;
    half = size >> 1;
    if (half == 0) return SQ_ONE;
    d = (2 * pos >= size) ? 2 * pos - size : size - 2 * pos;
    den = 4 * half * half;
    if (d * d >= den) return SQ_ONE;
    return ((d * d) << (2 * FB)) / den;
  endfunction

  function automatic longint unsigned rad_factor(longint unsigned x, longint unsigned y);
    longint unsigned tx, ty, s, r, t;
    tx = rad_term(x, m_width);
    ty = rad_term(y, m_height);
    if (tx >= SQ_ONE || ty >= SQ_ONE) return ONE;
    s = tx + ty;
    if (s >= SQ_ONE) return ONE;
    r = 0;
    for (int i = FB; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= s) r = t;
    end
    if (s - r * r > r) r++;
    return r;
  endfunction

  function automatic rgba_t fade_color(logic [CB-1:0] x, logic [CB-1:0] y);
    longint unsigned f, s, e;
    logic [CHAN_BITS-1:0] ch[NUM_CHAN];
    rgba_t c;
    case (m_mode)
      MODE_HORIZ:  f = lin_factor(x, m_width);
      MODE_VERT:   f = lin_factor(y, m_height);
      MODE_RADIAL: f = rad_factor(x, y);
      default:     f = 0;
    endcase
    for (int k = 0; k < NUM_CHAN; k++) begin
      s = m_start[COLOR_BITS-1-8*k -: 8];
      e = m_end[COLOR_BITS-1-8*k -: 8];
      ch[k] = 8'((s * f + e * (ONE - f) + (ONE >> 1)) >> FB);
    end
    c.red = ch[0];
    c.green = ch[1];
    c.blue = ch[2];
    c.alpha = ch[3];
    return c;
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(99);
    if (no_idle || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // driver: a word leaves the queue only once the previous one was taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) color_q.push_back(fade_color(in_pixel_x, in_pixel_y));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          in_pixel_x <= pixel_q[0].x;
          in_pixel_y <= pixel_q[0].y;
          void'(pixel_q.pop_front());
          in_valid <= 1'b1;
          in_gap <= rand_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and output stall generator
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, color_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (color_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected word %h %h %h %h", out_red_out,
                                  out_green_out, out_blue_out, out_alpha_out);
      end else begin
        checked <= checked + 1;
        if (out_red_out !== color_q[0].red || out_green_out !== color_q[0].green ||
            out_blue_out !== color_q[0].blue || out_alpha_out !== color_q[0].alpha) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: exp %h %h %h %h got %h %h %h %h", color_q[0].red,
                     color_q[0].green, color_q[0].blue, color_q[0].alpha, out_red_out,
                     out_green_out, out_blue_out, out_alpha_out);
        end
        void'(color_q.pop_front());
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      stall_left <= rand_gap();
      out_stall <= 1'b0;
    end
  end

  task automatic wait_drain();
    while (pixel_q.size() > 0 || in_valid || color_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; setup drops it after the last one
  task automatic cfg_write(cfg_idx_t idx, logic [COLOR_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  m_width = data[DIM_BITS-1:0];
      CFG_FRAME_HEIGHT: m_height = data[DIM_BITS-1:0];
      CFG_START_COLOR:  m_start = data;
      CFG_END_COLOR:    m_end = data;
      default:          m_mode = fade_mode_t'(data[1:0]);
    endcase
  endtask

  task automatic setup(int w, int h, logic [31:0] sc, logic [31:0] ec, fade_mode_t md);
    wait_drain();
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
    cfg_write(CFG_START_COLOR, sc);
    cfg_write(CFG_END_COLOR, ec);
    cfg_write(CFG_FADE_MODE, 32'(md));
    cfg_valid <= 1'b0;
    phases++;
  endtask

  task automatic push(int x, int y);
    coord_t c;
    c.x = CB'(x);
    c.y = CB'(y);
    pixel_q.push_back(c);
  endtask

  function automatic int pick_dim();
    case ($urandom_range(9))
      0: return 1;
      1: return 2;
      2: return 3;
      3: return 4096;
      4, 5: return $urandom_range(64, 4);
      default: return $urandom_range(4096, 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int w, h, n;
    fade_mode_t md;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // reset defaults first, then directed corners
    push(0, 0); push(639, 0); push(640, 5); push(4095, 4095); push(319, 100);
    no_idle = 1'b1;
    setup(640, 480, 32'h0, 32'hFFFF_FFFF, MODE_VERT);
    push(0, 0); push(7, 479); push(5, 239); push(0, 4095);
    setup(641, 481, 32'h12345678, 32'hFEDCBA98, MODE_RADIAL);
    push(320, 240); push(0, 0); push(640, 480); push(4095, 4095); push(320, 0);
    push(100, 200);
    no_idle = 1'b0;
    setup(1, 1, 32'hFFFF_FFFF, 32'h0, MODE_HORIZ);   // zero divisor
    push(0, 0); push(4095, 0);
    setup(2, 1, 32'hA5A5A5A5, 32'h5A5A5A5A, MODE_RADIAL);
    push(1, 0); push(0, 0);
    setup(4096, 4096, 32'h0, 32'hFFFF_FFFF, MODE_NONE);  // unused mode
    push(2048, 2048); push(4095, 0);
    for (int p = 0; p < 14; p++) begin
      w = pick_dim();
      h = pick_dim();
      md = ($urandom_range(15) == 0) ? MODE_NONE : fade_mode_t'($urandom_range(2));
      setup(w, h, pick_color(), pick_color(), md);
      no_idle = ($urandom_range(3) == 0);
      n = 80;
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0) push($urandom, $urandom);
        else push($urandom_range(w - 1), $urandom_range(h - 1));
        // sender holds off once until the pipe is empty
        if (p == 1 && i == n / 2) wait_drain();
      end
    end
    wait_drain();
    $display("%0d pixels checked over %0d register settings, all fade modes", checked, phases);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d failures", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== color_fade_pixel_generator.f =====
hw/rtl/cfpg_pkg.sv
hw/rtl/cfpg_front.sv
hw/rtl/cfpg_div.sv
hw/rtl/cfpg_sqrt.sv
hw/rtl/cfpg_blend.sv
hw/rtl/color_fade_pixel_generator.sv
verif/tb_top.sv
